// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the particle pool block.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int POOL_SIZE = 32;
   localparam int SLOT_W    = 6;
   localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

   localparam logic [0:0] REQ_EMIT = 1'b0;
   localparam logic [0:0] REQ_TICK = 1'b1;

   localparam logic [1:0] ST_EMITTED = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_LIVE    = 2'd2;
   localparam logic [1:0] ST_DONE    = 2'd3;

   localparam logic [0:0] CSR_THRESHOLD = 1'b0;
   localparam logic [0:0] CSR_SPIN      = 1'b1;

   localparam logic [15:0] THRESHOLD_RESET = 16'd256;
   localparam logic [31:0] SPIN_RESET      = 32'd65536;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EMIT_MUL,
      S_EMIT_REM,
      S_EMIT_DIV,
      S_EMIT_WRITE,
      S_TICK_READ,
      S_TICK_MUL,
      S_TICK_WRITE,
      S_OUT_WAIT,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic emit_mul;
      logic emit_rem;
      logic emit_div;
      logic emit_write;
      logic tick_start;
      logic tick_read;
      logic tick_mul;
      logic tick_write;
      logic tick_next;
      logic out_full;
      logic out_done;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic have_free;
      logic slot_active;
      logic slot_dies;
      logic last_slot;
   } stat_type;

endpackage

// ===== hw/rtl/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for emit and tick requests.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     out_busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EMIT_MUL;
         end
         S_EMIT_MUL: begin
            if (stat.is_tick) state_in = S_TICK_READ;
            else if (!stat.have_free) state_in = S_DONE;
            else state_in = S_EMIT_REM;
         end
         S_EMIT_REM:   state_in = S_EMIT_DIV;
         S_EMIT_DIV:   state_in = S_EMIT_WRITE;
         S_EMIT_WRITE: begin
            if (!out_busy) state_in = S_IDLE;
         end
         S_TICK_READ: begin
            if (!stat.slot_active) begin
               if (stat.last_slot) state_in = S_DONE;
            end else begin
               state_in = S_TICK_MUL;
            end
         end
         S_TICK_MUL: begin
            if (stat.slot_dies) state_in = stat.last_slot ? S_DONE : S_TICK_READ;
            else state_in = S_TICK_WRITE;
         end
         S_TICK_WRITE: begin
            if (!out_busy) state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: state_in = stat.last_slot ? S_DONE : S_TICK_READ;
         S_DONE: begin
            if (!out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_EMIT_MUL: begin
            cmd.emit_mul   = !stat.is_tick;
            cmd.tick_start = stat.is_tick;
         end
         S_EMIT_REM:   cmd.emit_rem = 1'b1;
         S_EMIT_DIV:   cmd.emit_div = 1'b1;
         S_EMIT_WRITE: cmd.emit_write = !out_busy;
         S_TICK_READ: begin
            cmd.tick_read = 1'b1;
            cmd.tick_next = !stat.slot_active && !stat.last_slot;
         end
         S_TICK_MUL: begin
            cmd.tick_mul  = 1'b1;
            cmd.tick_next = stat.slot_dies && !stat.last_slot;
         end
         S_TICK_WRITE: cmd.tick_write = !out_busy;
         S_OUT_WAIT:   cmd.tick_next = !stat.last_slot;
         S_DONE: begin
            cmd.out_full = !out_busy && !stat.is_tick;
            cmd.out_done = !out_busy && stat.is_tick;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== hw/rtl/pps_datapath.sv =====
// ----------------------------------------------------------------------------
// pps_datapath
// Slot stores, velocity variation and motion arithmetic, result register.
// ----------------------------------------------------------------------------
module pps_datapath import pps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   output logic               out_busy,
   input  logic               csr_valid,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_type,
   input  logic [23:0]        req_life_time,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_base_vx,
   input  logic signed [31:0] req_base_vy,
   input  logic signed [31:0] req_spread_x,
   input  logic signed [31:0] req_spread_y,
   input  logic [12:0]        req_rand_x,
   input  logic [12:0]        req_rand_y,
   input  logic [15:0]        req_delta,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_slot,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_angle,
   output logic [23:0]        rsp_life_left,
   output logic               rsp_last
);

   localparam logic [12:0] RAND_MOD  = 13'd5000;
   localparam logic [12:0] RAND_MID  = 13'd2500;
   localparam logic [31:0] DIV_CONST = 32'd2500;
   localparam logic [32:0] DIV_RECIP = 33'd7036874418; // ceil(2^44/2500)

   logic [15:0] thr_ff;
   logic [31:0] spin_ff;
   logic [POOL_SIZE-1:0] act_ff;

   logic [23:0] life_mem [POOL_SIZE];
   logic [31:0] px_mem   [POOL_SIZE];
   logic [31:0] py_mem   [POOL_SIZE];
   logic [31:0] vx_mem   [POOL_SIZE];
   logic [31:0] vy_mem   [POOL_SIZE];
   logic [31:0] rot_mem  [POOL_SIZE];
   logic [31:0] spn_mem  [POOL_SIZE];

   // request holding
   logic        typ_ff;
   logic [23:0] life_ff;
   logic [31:0] sx_ff, sy_ff, bx_ff, by_ff, spx_ff, spy_ff;
   logic [12:0] rx_ff, ry_ff;
   logic [15:0] dlt_ff;
   logic [IDX_W-1:0] idx_ff;

   // emit working values: |c*s|/2500 = |c|*q + |c|*r/2500 with |s| = 2500*q + r
   logic        negx_ff, negy_ff;
   logic [11:0] ax_ff, ay_ff;
   logic [31:0] smx_ff, smy_ff;
   logic [20:0] qsx_ff, qsy_ff;
   logic [31:0] apx_ff, apy_ff;
   logic [23:0] arx_ff, ary_ff;
   logic [31:0] varx_ff, vary_ff;

   // tick slot values
   logic [23:0] rl_ff;
   logic [31:0] rpx_ff, rpy_ff, rvx_ff, rvy_ff, rrot_ff, rspn_ff;
   logic [47:0] mx_ff, my_ff, mr_ff;

   // result register
   logic        ov_ff;
   logic [1:0]  ost_ff;
   logic [5:0]  osl_ff;
   logic [31:0] opx_ff, opy_ff, oan_ff;
   logic [23:0] olf_ff;
   logic        olast_ff;

   logic [IDX_W-1:0] free_idx;
   logic             have_free;

   always_comb begin
      free_idx  = '0;
      have_free = 1'b0;
      for (int i = POOL_SIZE - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_idx  = IDX_W'(i);
            have_free = 1'b1;
         end
      end
   end

   function automatic logic signed [13:0] centered(input logic [12:0] r);
      logic [12:0] rr;
      rr = (r >= RAND_MOD) ? r - RAND_MOD : r;
      return $signed({1'b0, rr}) - $signed({1'b0, RAND_MID});
   endfunction

   function automatic logic [11:0] mag12(input logic signed [13:0] c);
      logic signed [13:0] m;
      m = c[13] ? -c : c;
      return m[11:0];
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] s);
      return s[31] ? 32'(-s) : s;
   endfunction

   // floor(n/2500), exact for n below 2^34
   function automatic logic [20:0] div2500(input logic [31:0] n);
      logic [64:0] q;
      q = 65'(n) * 65'(DIV_RECIP);
      return q[64:44];
   endfunction

   function automatic logic [31:0] step(input logic [47:0] p);
      logic signed [47:0] sp;
      logic signed [47:0] adj;
      sp  = $signed(p);
      adj = sp[47] ? sp + 48'sd255 : sp;
      return 32'(adj >>> 8);
   endfunction

   logic signed [13:0] cenx, ceny;
   logic [11:0]        remx, remy;
   logic [31:0]        magx, magy;

   assign cenx = centered(rx_ff);
   assign ceny = centered(ry_ff);
   assign remx = 12'(smx_ff - 32'(qsx_ff) * DIV_CONST);
   assign remy = 12'(smy_ff - 32'(qsy_ff) * DIV_CONST);
   assign magx = apx_ff + 32'(div2500(32'(arx_ff)));
   assign magy = apy_ff + 32'(div2500(32'(ary_ff)));

   logic [23:0] life_sub;
   logic        dies;
   assign life_sub = rl_ff - 24'(dlt_ff);
   assign dies     = (rl_ff < 24'(dlt_ff)) || (life_sub <= 24'(thr_ff));

   assign out_busy = ov_ff && !rsp_ready;

   assign stat.is_tick     = typ_ff;
   assign stat.have_free   = have_free;
   assign stat.slot_active = act_ff[idx_ff];
   assign stat.slot_dies   = dies;
   assign stat.last_slot   = (idx_ff == IDX_W'(POOL_SIZE - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THRESHOLD_RESET;
         spin_ff <= SPIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff  <= csr_data[15:0];
            CSR_SPIN:      spin_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         typ_ff  <= req_type;
         life_ff <= req_life_time;
         sx_ff   <= req_start_x;
         sy_ff   <= req_start_y;
         bx_ff   <= req_base_vx;
         by_ff   <= req_base_vy;
         spx_ff  <= req_spread_x;
         spy_ff  <= req_spread_y;
         rx_ff   <= req_rand_x;
         ry_ff   <= req_rand_y;
         dlt_ff  <= req_delta;
      end
      if (cmd.emit_mul) begin
         idx_ff  <= free_idx;
         negx_ff <= cenx[13] ^ spx_ff[31];
         negy_ff <= ceny[13] ^ spy_ff[31];
         ax_ff   <= mag12(cenx);
         ay_ff   <= mag12(ceny);
         smx_ff  <= mag32(spx_ff);
         smy_ff  <= mag32(spy_ff);
         qsx_ff  <= div2500(mag32(spx_ff));
         qsy_ff  <= div2500(mag32(spy_ff));
      end
      if (cmd.emit_rem) begin
         apx_ff <= 32'(ax_ff) * 32'(qsx_ff);
         apy_ff <= 32'(ay_ff) * 32'(qsy_ff);
         arx_ff <= 24'(ax_ff) * 24'(remx);
         ary_ff <= 24'(ay_ff) * 24'(remy);
      end
      if (cmd.emit_div) begin
         varx_ff <= bx_ff + (negx_ff ? 32'(-magx) : magx);
         vary_ff <= by_ff + (negy_ff ? 32'(-magy) : magy);
      end
      if (cmd.tick_start) idx_ff <= '0;
      if (cmd.tick_next)  idx_ff <= idx_ff + 1'b1;
      if (cmd.tick_read) begin
         rl_ff   <= life_mem[idx_ff];
         rpx_ff  <= px_mem[idx_ff];
         rpy_ff  <= py_mem[idx_ff];
         rvx_ff  <= vx_mem[idx_ff];
         rvy_ff  <= vy_mem[idx_ff];
         rrot_ff <= rot_mem[idx_ff];
         rspn_ff <= spn_mem[idx_ff];
      end
      if (cmd.tick_mul) begin
         mx_ff <= 48'($signed(rvx_ff)  * $signed({1'b0, dlt_ff}));
         my_ff <= 48'($signed(rvy_ff)  * $signed({1'b0, dlt_ff}));
         mr_ff <= 48'($signed(rspn_ff) * $signed({1'b0, dlt_ff}));
      end
      if (cmd.emit_write) begin
         life_mem[idx_ff] <= life_ff;
         px_mem[idx_ff]   <= sx_ff;
         py_mem[idx_ff]   <= sy_ff;
         vx_mem[idx_ff]   <= varx_ff;
         vy_mem[idx_ff]   <= vary_ff;
         rot_mem[idx_ff]  <= '0;
         spn_mem[idx_ff]  <= spin_ff;
      end
      if (cmd.tick_write) begin
         life_mem[idx_ff] <= life_sub;
         px_mem[idx_ff]   <= rpx_ff + step(mx_ff);
         py_mem[idx_ff]   <= rpy_ff + step(my_ff);
         rot_mem[idx_ff]  <= rrot_ff + step(mr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
      end else begin
         if (cmd.emit_write) act_ff[idx_ff] <= 1'b1;
         if (cmd.tick_mul && dies) act_ff[idx_ff] <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (cmd.emit_write || cmd.tick_write || cmd.out_full || cmd.out_done) begin
         ov_ff <= 1'b1;
      end else if (rsp_ready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_write) begin
         ost_ff <= ST_EMITTED;
         osl_ff <= SLOT_W'(idx_ff);
         opx_ff <= sx_ff;
         opy_ff <= sy_ff;
         oan_ff <= '0;
         olf_ff <= life_ff;
         olast_ff <= 1'b1;
      end else if (cmd.tick_write) begin
         ost_ff <= ST_LIVE;
         osl_ff <= SLOT_W'(idx_ff);
         opx_ff <= rpx_ff + step(mx_ff);
         opy_ff <= rpy_ff + step(my_ff);
         oan_ff <= rrot_ff + step(mr_ff);
         olf_ff <= life_sub;
         olast_ff <= 1'b0;
      end else if (cmd.out_full || cmd.out_done) begin
         ost_ff <= cmd.out_done ? ST_DONE : ST_FULL;
         osl_ff <= '0;
         opx_ff <= '0;
         opy_ff <= '0;
         oan_ff <= '0;
         olf_ff <= '0;
         olast_ff <= 1'b1;
      end
   end

   assign rsp_valid     = ov_ff;
   assign rsp_status    = ost_ff;
   assign rsp_slot      = osl_ff;
   assign rsp_pos_x     = opx_ff;
   assign rsp_pos_y     = opy_ff;
   assign rsp_angle     = oan_ff;
   assign rsp_life_left = olf_ff;
   assign rsp_last      = olast_ff;

endmodule

// ===== hw/rtl/particle_pool_step.sv =====
// ----------------------------------------------------------------------------
// particle_pool_step
// Particle slot pool with emit and tick requests.
// ----------------------------------------------------------------------------
// Usage: req_* is a valid/ready channel of requests. An emit request claims
// the lowest free slot and returns one item (emitted or pool full). A tick
// request walks all 32 slots in order, returns one item per surviving particle
// and ends with a done item whose last bit is set.
// Sequence: an emit passes the multiply, remainder, divide and write
// states before its result is registered (pool full goes straight to
// done), and the next request is taken back in idle. A tick visits each
// slot in order: a free slot is only read; a live particle is read,
// multiplied, written back and advanced; a slot that dies is read and
// multiplied. The walk is set by the single read port of the slot stores.
// The csr_ channel writes death_threshold (index 0) and spin_rate (index 1);
// always ready, it must be used only while the block is idle (not enforced).
// Reset clears all active marks and restores the register defaults.
// A stalled rsp_ready holds the result register and pauses the walk.
// ----------------------------------------------------------------------------
module particle_pool_step import pps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [23:0]        req_life_time,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_base_vx,
   input  logic signed [31:0] req_base_vy,
   input  logic signed [31:0] req_spread_x,
   input  logic signed [31:0] req_spread_y,
   input  logic [12:0]        req_rand_x,
   input  logic [12:0]        req_rand_y,
   input  logic [15:0]        req_delta,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_slot,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_angle,
   output logic [23:0]        rsp_life_left,
   output logic               rsp_last
);

   cmd_type  cmd;
   stat_type stat;
   logic     out_busy;

   assign csr_ready = 1'b1;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_busy  (out_busy),
      .stat      (stat),
      .cmd       (cmd)
   );

   pps_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .out_busy      (out_busy),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_type      (req_type),
      .req_life_time (req_life_time),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_base_vx   (req_base_vx),
      .req_base_vy   (req_base_vy),
      .req_spread_x  (req_spread_x),
      .req_spread_y  (req_spread_y),
      .req_rand_x    (req_rand_x),
      .req_rand_y    (req_rand_y),
      .req_delta     (req_delta),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_angle     (rsp_angle),
      .rsp_life_left (rsp_life_left),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== verif/tb_particle_pool_step.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_particle_pool_step
// Self-checking bench for the particle pool: directed and random emit/tick
// requests with random idling on both channels, predicted results checked
// field by field, register writes between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_particle_pool_step import pps_pkg::*; ();

   typedef struct packed {
      logic        kind;
      logic [23:0] life_time;
      logic [31:0] start_x;
      logic [31:0] start_y;
      logic [31:0] base_vx;
      logic [31:0] base_vy;
      logic [31:0] spread_x;
      logic [31:0] spread_y;
      logic [12:0] rand_x;
      logic [12:0] rand_y;
      logic [15:0] delta;
   } particle_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] angle;
      logic [23:0] life_left;
      logic        last;
   } particle_rsp_type;

   localparam int WATCHDOG_LIMIT = 4000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [0:0]         csr_index = CSR_THRESHOLD;
   logic [31:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = REQ_EMIT;
   logic [23:0]        req_life_time = '0;
   logic signed [31:0] req_start_x = '0, req_start_y = '0;
   logic signed [31:0] req_base_vx = '0, req_base_vy = '0;
   logic signed [31:0] req_spread_x = '0, req_spread_y = '0;
   logic [12:0]        req_rand_x = '0, req_rand_y = '0;
   logic [15:0]        req_delta = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_slot;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_angle;
   logic [23:0]        rsp_life_left;
   logic               rsp_last;

   particle_pool_step dut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [15:0] death_threshold;
   logic [31:0] spin_rate;
   logic        slot_live [POOL_SIZE];
   logic [23:0] slot_life [POOL_SIZE];
   logic [31:0] slot_px [POOL_SIZE], slot_py [POOL_SIZE];
   logic [31:0] slot_vx [POOL_SIZE], slot_vy [POOL_SIZE];
   logic [31:0] slot_rot [POOL_SIZE], slot_spin [POOL_SIZE];

   particle_req_type pending_reqs [$];
   particle_rsp_type expected_rsps [$];
   int  error_count = 0;
   int  emits_sent = 0, ticks_sent = 0, full_seen = 0, live_seen = 0;
   int  idle_cycles = 0;
   bit  stim_done = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [31:0] vary_velocity(logic [31:0] base, logic [31:0] spread,
                                                 logic [12:0] r);
      longint rr, v;
      rr = r;
      if (rr >= 5000) rr -= 5000;
      v = ((rr - 2500) * longint'($signed(spread))) / 2500;
      return 32'(longint'($signed(base)) + v);
   endfunction

   function automatic logic [31:0] motion_step(logic [31:0] rate, logic [15:0] d);
      longint p;
      p = longint'($signed(rate)) * longint'(d);
      return 32'(p / 256);
   endfunction

   function automatic particle_rsp_type make_rsp(logic [1:0] st, int s, logic [31:0] px,
                                                 logic [31:0] py, logic [31:0] ang,
                                                 logic [23:0] life, logic lst);
      particle_rsp_type r;
      r.status = st; r.slot = 6'(s); r.pos_x = px; r.pos_y = py;
      r.angle = ang; r.life_left = life; r.last = lst;
      return r;
   endfunction

   task automatic predict_pool(input particle_req_type q);
      int  claimed;
      if (q.kind == REQ_EMIT) begin
         emits_sent++;
         claimed = -1;
         for (int i = 0; i < POOL_SIZE; i++)
            if (claimed < 0 && !slot_live[i]) claimed = i;
         if (claimed < 0) begin
            expected_rsps.push_back(make_rsp(ST_FULL, 0, 0, 0, 0, 0, 1'b1));
         end else begin
            slot_live[claimed] = 1'b1;
            slot_life[claimed] = q.life_time;
            slot_px[claimed] = q.start_x;
            slot_py[claimed] = q.start_y;
            slot_vx[claimed] = vary_velocity(q.base_vx, q.spread_x, q.rand_x);
            slot_vy[claimed] = vary_velocity(q.base_vy, q.spread_y, q.rand_y);
            slot_rot[claimed] = '0;
            slot_spin[claimed] = spin_rate;
            expected_rsps.push_back(make_rsp(ST_EMITTED, claimed, q.start_x, q.start_y,
                                             0, q.life_time, 1'b1));
         end
      end else begin
         ticks_sent++;
         for (int i = 0; i < POOL_SIZE; i++) begin
            if (!slot_live[i]) continue;
            if (slot_life[i] < q.delta || slot_life[i] - q.delta <= death_threshold) begin
               slot_live[i] = 1'b0;
               continue;
            end
            slot_life[i] = slot_life[i] - q.delta;
            slot_rot[i] += motion_step(slot_spin[i], q.delta);
            slot_px[i] += motion_step(slot_vx[i], q.delta);
            slot_py[i] += motion_step(slot_vy[i], q.delta);
            expected_rsps.push_back(make_rsp(ST_LIVE, i, slot_px[i], slot_py[i],
                                             slot_rot[i], slot_life[i], 1'b0));
         end
         expected_rsps.push_back(make_rsp(ST_DONE, 0, 0, 0, 0, 0, 1'b1));
      end
   endtask

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold
      end else begin
         if (req_valid) begin
            predict_pool(pending_reqs.pop_front());
            req_gap = $urandom_range(0, 4);
         end
         if (pending_reqs.size() > 0 && req_gap == 0) begin
            req_valid <= 1'b1;
            req_type <= pending_reqs[0].kind;
            req_life_time <= pending_reqs[0].life_time;
            req_start_x <= pending_reqs[0].start_x;
            req_start_y <= pending_reqs[0].start_y;
            req_base_vx <= pending_reqs[0].base_vx;
            req_base_vy <= pending_reqs[0].base_vy;
            req_spread_x <= pending_reqs[0].spread_x;
            req_spread_y <= pending_reqs[0].spread_y;
            req_rand_x <= pending_reqs[0].rand_x;
            req_rand_y <= pending_reqs[0].rand_y;
            req_delta <= pending_reqs[0].delta;
         end else begin
            req_valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      particle_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item", 32'(rsp_status), 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status == ST_FULL) full_seen++;
               if (rsp_status == ST_LIVE) live_seen++;
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_slot !== want.slot)
                  report_mismatch("slot", 32'(rsp_slot), 32'(want.slot));
               if (rsp_pos_x !== want.pos_x) report_mismatch("pos_x", rsp_pos_x, want.pos_x);
               if (rsp_pos_y !== want.pos_y) report_mismatch("pos_y", rsp_pos_y, want.pos_y);
               if (rsp_angle !== want.angle) report_mismatch("angle", rsp_angle, want.angle);
               if (rsp_life_left !== want.life_left)
                  report_mismatch("life_left", 32'(rsp_life_left), 32'(want.life_left));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
            rsp_gap = $urandom_range(0, 4);
         end
         if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d items outstanding", expected_rsps.size());
         $display("tb_particle_pool_step failed");
         $finish;
      end
   end

   function automatic particle_req_type emit_req(logic [23:0] life);
      particle_req_type q;
      q.kind = REQ_EMIT;
      q.life_time = life;
      q.start_x = $urandom; q.start_y = $urandom;
      q.base_vx = $urandom; q.base_vy = $urandom;
      q.spread_x = $urandom; q.spread_y = $urandom;
      q.rand_x = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4999));
      q.rand_y = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4999));
      q.delta = 16'($urandom);
      return q;
   endfunction

   function automatic particle_req_type tick_req(logic [15:0] d);
      particle_req_type q;
      q = emit_req(24'($urandom));
      q.kind = REQ_TICK;
      q.delta = d;
      return q;
   endfunction

   task automatic run_phase();
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_THRESHOLD) death_threshold = val[15:0];
      else spin_rate = val;
   endtask

   initial begin
      particle_req_type q;
      death_threshold = THRESHOLD_RESET;
      spin_rate = SPIN_RESET;
      for (int i = 0; i < POOL_SIZE; i++) slot_live[i] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, field extremes, odd draws, short life, full pool
      pending_reqs.push_back(tick_req(16'h0100));
      q = emit_req(24'hFFFFFF);
      q.start_x = 32'h7FFFFFFF; q.start_y = 32'h80000000;
      q.base_vx = 32'h7FFFFFFF; q.spread_x = 32'h80000000; q.rand_x = 13'd0;
      q.base_vy = 32'h80000000; q.spread_y = 32'h7FFFFFFF; q.rand_y = 13'd4999;
      pending_reqs.push_back(q);
      q = emit_req(24'h000000); q.rand_x = 13'h1FFF; q.rand_y = 13'd5000;
      pending_reqs.push_back(q);
      q = emit_req(24'h000100); q.rand_x = 13'd2500; q.rand_y = 13'd2500;
      pending_reqs.push_back(q);
      pending_reqs.push_back(tick_req(16'hFFFF));
      pending_reqs.push_back(tick_req(16'h0000));
      pending_reqs.push_back(tick_req(16'h0101));
      run_phase();

      write_reg(CSR_THRESHOLD, 32'h0000_0000);
      write_reg(CSR_SPIN, 32'h8000_0000);
      for (int i = 0; i < POOL_SIZE + 2; i++) pending_reqs.push_back(emit_req(24'($urandom)));
      pending_reqs.push_back(tick_req(16'($urandom)));
      pending_reqs.push_back(tick_req(16'h0000));
      run_phase();

      // random phases under several register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin write_reg(CSR_THRESHOLD, 32'hFFFF); write_reg(CSR_SPIN, 32'h7FFF_FFFF); end
            1: begin write_reg(CSR_THRESHOLD, 32'h0100); write_reg(CSR_SPIN, 32'hFFFF_FFFF); end
            default: begin write_reg(CSR_THRESHOLD, $urandom_range(0, 2048));
                           write_reg(CSR_SPIN, $urandom); end
         endcase
         for (int n = 0; n < 36; n++) begin
            if ($urandom_range(0, 3) == 0)
               pending_reqs.push_back(tick_req($urandom_range(0, 3) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(0, 2048))));
            else
               pending_reqs.push_back(emit_req($urandom_range(0, 3) == 0 ? 24'($urandom)
                                               : 24'($urandom_range(0, 16384))));
         end
         run_phase();
      end
      stim_done = 1'b1;

      $display("covered %0d emits and %0d ticks", emits_sent, ticks_sent);
      $display("saw %0d live-particle items and %0d pool-full items", live_seen, full_seen);
      if (error_count == 0) begin
         $display("tb_particle_pool_step passed");
      end else begin
         $display("tb_particle_pool_step failed");
      end
      $finish;
   end

endmodule
